// ===== hw/rtl/frx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the framed
// packet receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int HEADER_BYTES = 27;
  localparam int CMD_AT       = 24;
  localparam int LEN_HI_AT    = 25;
  localparam int LEN_LO_AT    = 26;
  localparam int HDR_KEEP     = 25;
  localparam int QUEUE_DEPTH  = 2;

  localparam int PAY_AW    = $clog2(BUFFER_BYTES);
  localparam int HDR_AW    = $clog2(HEADER_BYTES);
  localparam int IDX_W     = (PAY_AW > HDR_AW) ? PAY_AW : HDR_AW;
  localparam int CUR_W     = $clog2(HEADER_BYTES + BUFFER_BYTES + 1);
  localparam int LEN_W     = 16;
  localparam int DLEN_W    = 6;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] PREAMBLE_WORD = 32'h55AA_7892;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]  CMD_IDENTIFY  = 8'd255;
  localparam logic [7:0]  CMD_DESCRIBE  = 8'd254;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LOW  = 2'd2;

  typedef enum logic [1:0] {
    OP_RESTART,
    OP_HEADER,
    OP_PAYLOAD,
    OP_SKIP
  } op_e;

  typedef enum logic [1:0] {
    KIND_APP   = 2'd0,
    KIND_DESC  = 2'd1,
    KIND_IDENT = 2'd2
  } kind_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        data;
    logic [IDX_W-1:0]  idx;
    logic              capture;
    logic              check;
    logic [DLEN_W-1:0] len;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] high;
    logic [ADDR_W-1:0] mid;
    logic [ADDR_W-1:0] low;
  } addr_t;

  typedef struct packed {
    addr_t             sender;
    logic [7:0]        command;
    kind_e             service_kind;
    logic              broadcast;
    logic [DLEN_W-1:0] data_length;
    logic [DLEN_W-1:0] byte_index;
    logic [7:0]        payload_byte;
    logic              payload_valid;
    logic              last;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/framed_packet_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_core
// Receiver for preamble-framed packets with a CRC-16/Modbus check.
// ----------------------------------------------------------------------------
// Received bytes enter through push/full; a transfer takes place on a rising
// edge with push high and full low. A parser classifies each byte and hands it
// through a two-entry queue to the back end, which runs the CRC and stores the
// header and payload, one byte per cycle. While the back end is free a byte
// can be taken in every cycle.
// When a frame passes its CRC and address check, its payload leaves through
// empty/pop as one result per byte (one result for an empty payload). The
// first result appears after the last CRC byte, once the back end has read
// the payload byte in state S_READ and moved to S_HOLD; for an empty payload
// it appears in the cycle after that byte. Each further result passes
// through S_READ likewise after the previous one is popped. During a run the
// back end takes no bytes from the queue, so full rises once two more bytes
// wait; a stalled receiver holds the current result and everything behind it.
// Own address registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i.
// Reset clears the address registers, the preamble window, the frame position
// and the queue, and presets the CRC. The header and payload stores are not
// cleared; bytes before the first preamble are parsed as a frame.
// ----------------------------------------------------------------------------
module framed_packet_receiver_core import frx_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           rx_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [31:0]          sender_high_o,
  output logic [31:0]          sender_mid_o,
  output logic [31:0]          sender_low_o,
  output logic [7:0]           command_o,
  output logic [1:0]           service_kind_o,
  output logic                 broadcast_o,
  output logic [DLEN_W-1:0]    data_length_o,
  output logic [DLEN_W-1:0]    byte_index_o,
  output logic [7:0]           payload_byte_o,
  output logic                 payload_valid_o,
  output logic                 last_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i
);

  addr_t   own_q;
  item_t   f_item, q_item;
  logic    f_push, q_full, q_empty, q_pop, res_valid;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADDR_HIGH: own_q.high <= cfg_wdata_i;
        CFG_ADDR_MID:  own_q.mid  <= cfg_wdata_i;
        CFG_ADDR_LOW:  own_q.low  <= cfg_wdata_i;
        default:       own_q      <= own_q;
      endcase
    end
  end

  frx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .q_full_i  (q_full),
    .rx_byte_i (rx_byte_i),
    .q_push_o  (f_push),
    .item_o    (f_item)
  );

  frx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  frx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .own_addr_i  (own_q),
    .q_empty_i   (q_empty),
    .item_i      (q_item),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign full            = q_full;
  assign empty           = !res_valid;
  assign sender_high_o   = res.sender.high;
  assign sender_mid_o    = res.sender.mid;
  assign sender_low_o    = res.sender.low;
  assign command_o       = res.command;
  assign service_kind_o  = res.service_kind;
  assign broadcast_o     = res.broadcast;
  assign data_length_o   = res.data_length;
  assign byte_index_o    = res.byte_index;
  assign payload_byte_o  = res.payload_byte;
  assign payload_valid_o = res.payload_valid;
  assign last_o          = res.last;

  a_no_drain_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !q_pop)
    else $error("queue drained while a result is pending");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && last_o) |=> empty)
    else $error("result still shown after the final transfer of a run");

  a_empty_payload_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !payload_valid_o) |-> (last_o && byte_index_o == '0 && data_length_o == '0))
    else $error("malformed result for an empty payload");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && payload_valid_o) |-> (byte_index_o < data_length_o))
    else $error("payload index beyond frame length");

endmodule

// ===== hw/rtl/frx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frx_queue
// Short queue of classified bytes between the front parser and the back end.
// ----------------------------------------------------------------------------
module frx_queue import frx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  item_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/frx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frx_front
// Byte parser: preamble search, frame position tracking and length capture.
// Each accepted byte leaves as one classified item for the back end.
// ----------------------------------------------------------------------------
module frx_front import frx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       q_full_i,
  input  logic [7:0] rx_byte_i,
  output logic       q_push_o,
  output item_t      item_o
);

  logic [31:0]      win_q, win_d;
  logic [CUR_W-1:0] cur_q, cur_d, cur_inc;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [CUR_W-1:0] pay_off;
  logic [LEN_W:0]   cap_at, chk_at;

  assign q_push_o = push_i && !q_full_i;
  assign cur_inc  = cur_q + CUR_W'(1);
  assign pay_off  = cur_q - CUR_W'(HEADER_BYTES);
  // The first CRC byte sits one past the payload; the check falls on the second.
  assign cap_at   = {1'b0, len_q} + (LEN_W + 1)'(HEADER_BYTES + 1);
  assign chk_at   = {1'b0, len_q} + (LEN_W + 1)'(HEADER_BYTES + 2);

  always_comb begin
    win_d          = {win_q[23:0], rx_byte_i};
    cur_d          = cur_q;
    len_hi_d       = len_hi_q;
    len_d          = len_q;
    item_o.op      = OP_SKIP;
    item_o.data    = rx_byte_i;
    item_o.idx     = '0;
    item_o.capture = 1'b0;
    item_o.check   = 1'b0;
    item_o.len     = len_q[DLEN_W-1:0];
    priority if (win_d == PREAMBLE_WORD) begin
      item_o.op = OP_RESTART;
      cur_d     = '0;
    end else if (cur_q < CUR_W'(HEADER_BYTES)) begin
      item_o.op  = OP_HEADER;
      item_o.idx = IDX_W'(cur_q);
      cur_d      = cur_inc;
      if (cur_q == CUR_W'(LEN_HI_AT)) begin
        len_hi_d = rx_byte_i;
      end
      if (cur_q == CUR_W'(LEN_LO_AT)) begin
        len_d = {len_hi_q, rx_byte_i};
      end
    end else if (cur_q < CUR_W'(HEADER_BYTES + BUFFER_BYTES)) begin
      item_o.op      = OP_PAYLOAD;
      item_o.idx     = IDX_W'(pay_off[PAY_AW-1:0]);
      item_o.capture = (cap_at == (LEN_W + 1)'(cur_inc));
      item_o.check   = (chk_at == (LEN_W + 1)'(cur_inc));
      cur_d          = cur_inc;
    end else begin
      item_o.op = OP_SKIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      cur_q    <= '0;
      len_hi_q <= '0;
      len_q    <= '0;
    end else if (q_push_o) begin
      win_q    <= win_d;
      cur_q    <= cur_d;
      len_hi_q <= len_hi_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== hw/rtl/frx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frx_back
// Executes classified bytes: CRC, header and payload storage, the frame
// check, and readout of an accepted frame's payload as a run of results.
// ----------------------------------------------------------------------------
module frx_back import frx_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  addr_t   own_addr_i,
  input  logic    q_empty_i,
  input  item_t   item_i,
  output logic    q_pop_o,
  input  logic    res_pop_i,
  output logic    res_valid_o,
  output result_t res_o
);

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_READ = 3'b010,
    S_HOLD = 3'b100
  } bstate_e;

  bstate_e           state_q, state_d;
  logic [15:0]       crc_q, crc_d, crc_step;
  logic [15:0]       capt_q, capt_d;
  logic [7:0]        prev_q, prev_d;
  logic [DLEN_W-1:0] len_q, len_d;
  logic [DLEN_W-1:0] k_q, k_d;
  logic [7:0]        hdr_q [HDR_KEEP];
  logic [7:0]        pay_mem [BUFFER_BYTES];
  logic [7:0]        rd_q;
  logic              hdr_we, pay_we, rd_en;
  addr_t             target;
  logic              bcast, own_hit, frame_ok, is_last;

  assign target.high = {hdr_q[12], hdr_q[13], hdr_q[14], hdr_q[15]};
  assign target.mid  = {hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19]};
  assign target.low  = {hdr_q[20], hdr_q[21], hdr_q[22], hdr_q[23]};
  assign bcast       = (target == '0);
  assign own_hit     = (target == own_addr_i);

  assign q_pop_o  = (state_q == S_RUN) && !q_empty_i;
  assign crc_step = crc16_byte(crc_q, item_i.data);
  assign hdr_we   = q_pop_o && (item_i.op == OP_HEADER) &&
                    (item_i.idx < IDX_W'(HDR_KEEP));
  assign pay_we   = q_pop_o && (item_i.op == OP_PAYLOAD);
  assign frame_ok = pay_we && item_i.check && ({prev_q, item_i.data} == capt_q) &&
                    (bcast || own_hit);
  assign rd_en    = (state_q == S_READ);
  assign is_last  = (len_q == '0) || (k_q == len_q - DLEN_W'(1));

  always_comb begin
    state_d = state_q;
    crc_d   = crc_q;
    capt_d  = capt_q;
    prev_d  = prev_q;
    len_d   = len_q;
    k_d     = k_q;
    unique case (state_q)
      S_RUN: begin
        if (q_pop_o) begin
          unique case (item_i.op)
            OP_RESTART: crc_d = CRC_INIT;
            OP_HEADER:  crc_d = crc_step;
            OP_PAYLOAD: begin
              crc_d  = crc_step;
              prev_d = item_i.data;
              if (item_i.capture) begin
                capt_d = crc_q;
              end
            end
            OP_SKIP:    crc_d = crc_step;
            default:    crc_d = crc_q;
          endcase
          if (frame_ok) begin
            len_d   = item_i.len;
            k_d     = '0;
            state_d = (item_i.len == '0) ? S_HOLD : S_READ;
          end
        end
      end
      S_READ: state_d = S_HOLD;
      S_HOLD: begin
        if (res_pop_i) begin
          if (is_last) begin
            state_d = S_RUN;
          end else begin
            k_d     = k_q + DLEN_W'(1);
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      crc_q   <= CRC_INIT;
      capt_q  <= '0;
      prev_q  <= '0;
      len_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      crc_q   <= crc_d;
      capt_q  <= capt_d;
      prev_q  <= prev_d;
      len_q   <= len_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[item_i.idx[HDR_AW-1:0]] <= item_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[item_i.idx[PAY_AW-1:0]] <= item_i.data;
    end
    if (rd_en) begin
      rd_q <= pay_mem[k_q[PAY_AW-1:0]];
    end
  end

  // Header and length stay put while a run is read out, since no bytes are
  // taken from the queue until the last result has gone.
  assign res_valid_o         = (state_q == S_HOLD);
  assign res_o.sender.high   = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
  assign res_o.sender.mid    = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
  assign res_o.sender.low    = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
  assign res_o.command       = hdr_q[CMD_AT];
  assign res_o.service_kind  = (hdr_q[CMD_AT] == CMD_IDENTIFY) ? KIND_IDENT :
                               (hdr_q[CMD_AT] == CMD_DESCRIBE) ? KIND_DESC : KIND_APP;
  assign res_o.broadcast     = bcast;
  assign res_o.data_length   = len_q;
  assign res_o.byte_index    = k_q;
  assign res_o.payload_byte  = (len_q == '0) ? 8'h00 : rd_q;
  assign res_o.payload_valid = (len_q != '0);
  assign res_o.last          = is_last;

endmodule
